// ===== sv/ehd_pkg.sv =====
// ehd_pkg: types and codes shared by the error history deque
// item structs, operation codes, controller command and status groups
// depends on nothing
`default_nettype none

package ehd_pkg;

	localparam logic [2:0] OP_PUSH     = 3'd0;
	localparam logic [2:0] OP_POP_OLD  = 3'd1;
	localparam logic [2:0] OP_POP_NEW  = 3'd2;
	localparam logic [2:0] OP_CLEAR    = 3'd3;
	localparam logic [2:0] OP_READ_POS = 3'd4;

	localparam logic [2:0] REG_EMPTY_CODE = 3'd0;

	typedef struct packed {
		logic [2:0]         operation;
		logic signed [31:0] code_in;
		logic [5:0]         position;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] code_out;
		logic [63:0]        op_id;
		logic [5:0]         depth_out;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic push;
		logic pop_old;
		logic pop_new;
		logic clear;
		logic rd_pos;
		logic resp;
	} ctl_cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       empty;
		logic       pos_ok;
	} ctl_sts_t;

endpackage

`default_nettype wire

// ===== sv/error_history_deque_unit.sv =====
// error_history_deque_unit: bounded error code history, oldest dropped when full
// result strobed on done in the response state that follows the execute state
// no new item is taken until the last has left the execute and response steps
// the receiver cannot stall; done is high for exactly one cycle per item
// reset: history empty, op id counter at 1, empty code 0; no clearing pass
// depends on ehd_pkg, ehd_ctrl, ehd_dpath
`default_nettype none

module error_history_deque_unit #(
	parameter int CAPACITY = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               start,
	output logic                    busy,
	input  wire ehd_pkg::in_item_t  in_item,
	output logic                    done,
	output ehd_pkg::out_item_t      result
);
	import ehd_pkg::*;

	logic [31:0] empty_code_q;
	logic        reg_hit;
	ctl_cmd_t    cmd;
	ctl_sts_t    sts;

	assign pready  = 1'b1;
	assign reg_hit = (paddr == REG_EMPTY_CODE);
	assign prdata  = reg_hit ? empty_code_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_code_q <= 32'd0;
		end else if (psel && penable && pwrite && reg_hit) begin
			empty_code_q <= pwdata;
		end
	end

	ehd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.sts    (sts),
		.cmd    (cmd)
	);

	ehd_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_item    (in_item),
		.empty_code (empty_code_q),
		.cmd        (cmd),
		.sts        (sts),
		.result     (result)
	);

endmodule

`default_nettype wire

// ===== sv/ehd_ctrl.sv =====
// ehd_ctrl: sequencer for the error history deque
// takes an item, issues one execute step and one response step
// depends on ehd_pkg
`default_nettype none

module ehd_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	output logic                   done,
	input  wire ehd_pkg::ctl_sts_t sts,
	output ehd_pkg::ctl_cmd_t      cmd
);
	import ehd_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_RESP = 2'd2;

	logic [1:0] state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_EXEC;
				end
				ST_EXEC: state_q <= ST_RESP;
				ST_RESP: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd      = '0;
		cmd.load = (state_q == ST_IDLE) && start;
		cmd.resp = (state_q == ST_RESP);
		if (state_q == ST_EXEC) begin
			cmd.exec = 1'b1;
			case (sts.op)
				OP_PUSH:     cmd.push    = 1'b1;
				OP_POP_OLD:  cmd.pop_old = !sts.empty;
				OP_POP_NEW:  cmd.pop_new = !sts.empty;
				OP_CLEAR:    cmd.clear   = 1'b1;
				OP_READ_POS: cmd.rd_pos  = sts.pos_ok;
				default: ;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = cmd.resp;

endmodule

`default_nettype wire

// ===== sv/ehd_dpath.sv =====
// ehd_dpath: storage and arithmetic for the error history deque
// circular code memory, fill level, newest pointer, op id counter
// depends on ehd_pkg
`default_nettype none

module ehd_dpath #(
	parameter int CAPACITY = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ehd_pkg::in_item_t  in_item,
	input  wire logic [31:0]        empty_code,
	input  wire ehd_pkg::ctl_cmd_t  cmd,
	output ehd_pkg::ctl_sts_t       sts,
	output ehd_pkg::out_item_t      result
);
	import ehd_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int FW = $clog2(CAPACITY + 1);
	localparam int PW = FW + 6;

	logic [31:0]   mem [CAPACITY];

	logic [2:0]    op_q;
	logic [31:0]   code_q;
	logic [5:0]    pos_q;
	logic [FW-1:0] fill_q;
	logic [AW-1:0] top_q;
	logic [63:0]   idc_q;
	logic [63:0]   id_res_q;
	logic          use_mem_q;
	logic [31:0]   rdata_q;

	logic [PW-1:0] pos_ext;
	logic [PW-1:0] fill_ext;
	logic [PW-1:0] off_pos_w;
	logic [PW-1:0] off_old_w;
	logic [AW-1:0] off;
	logic [AW:0]   sub_w;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] top_inc;
	logic [AW-1:0] top_dec;
	logic          full;
	logic          rd_en;

	assign pos_ext   = {{FW{1'b0}}, pos_q};
	assign fill_ext  = {6'b0, fill_q};
	assign off_pos_w = pos_ext - PW'(1);
	assign off_old_w = fill_ext - PW'(1);
	assign full      = (fill_q == FW'(CAPACITY));
	assign rd_en     = cmd.pop_old | cmd.pop_new | cmd.rd_pos;

	always_comb begin
		off = '0;
		if (cmd.pop_old) off = off_old_w[AW-1:0];
		else if (cmd.rd_pos) off = off_pos_w[AW-1:0];
	end

	assign sub_w   = {1'b0, top_q} + (AW+1)'(CAPACITY) - {1'b0, off};
	assign rd_addr = (sub_w >= (AW+1)'(CAPACITY)) ? AW'(sub_w - (AW+1)'(CAPACITY))
	                                              : sub_w[AW-1:0];
	assign top_inc = (top_q == AW'(CAPACITY - 1)) ? '0 : top_q + AW'(1);
	assign top_dec = (top_q == '0) ? AW'(CAPACITY - 1) : top_q - AW'(1);

	assign sts.op     = op_q;
	assign sts.empty  = (fill_q == '0);
	assign sts.pos_ok = (pos_q != '0) && (pos_ext <= fill_ext);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= in_item.operation;
			code_q <= in_item.code_in;
			pos_q  <= in_item.position;
		end
		if (cmd.push) mem[top_inc] <= code_q;
		if (rd_en) rdata_q <= mem[rd_addr];
		if (cmd.exec) begin
			id_res_q  <= cmd.push ? idc_q : 64'd0;
			use_mem_q <= rd_en;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			top_q  <= '0;
			idc_q  <= 64'd1;
		end else begin
			if (cmd.push) begin
				top_q <= top_inc;
				idc_q <= idc_q + 64'd1;
				if (!full) fill_q <= fill_q + FW'(1);
			end
			if (cmd.pop_new) begin
				top_q  <= top_dec;
				fill_q <= fill_q - FW'(1);
			end
			if (cmd.pop_old) fill_q <= fill_q - FW'(1);
			if (cmd.clear) fill_q <= '0;
		end
	end

	assign result.code_out  = use_mem_q ? rdata_q : empty_code;
	assign result.op_id     = id_res_q;
	assign result.depth_out = fill_ext[5:0];

endmodule

`default_nettype wire
